FILE: rtl/rbf_pkg.sv
// Shared types, constants and codes for the ring buffer FIFO.
package rbf_pkg;

    // Built capacity and entry width
    localparam int CAPACITY  = 16;
    localparam int DATA_BITS = 8;

    // Derived widths
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SIZE_W = 5;
    localparam int CFG_IDX_W = 1;

    // Marker returned when popping or removing from an empty queue
    localparam logic [DATA_BITS-1:0] EMPTY_MARK = DATA_BITS'(35);

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_FLUSH  = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_EMPTY       = 2'd1,
        STAT_REFUSED     = 2'd2,
        STAT_OVERWRITTEN = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the incoming command
        logic exec;   // update pointers, access storage, register result
    } dp_cmd_t;

endpackage

FILE: rtl/ring_buffer_fifo_with_back_removal_top.sv
// Top level of the ring buffer FIFO with push, pop, remove-newest and flush.
//
// An operation runs as a sequence: start is taken while busy is low,
// the execute state updates the pointers and performs the single storage
// write or registered storage read, and the response state presents the
// result with result_valid high for exactly one cycle. The command capture
// register and the registered read port of the storage array lie between
// start and the result. busy is high from the cycle after a transfer
// until the result cycle ends, so no new operation starts before then. The
// receiver cannot stall: the result must be taken in the cycle that
// result_valid is high. Configuration writes are always accepted
// (cfg_ready is tied high) and should be made only while the block is idle.
module ring_buffer_fifo_with_back_removal_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      func,
    input  logic [rbf_pkg::DATA_BITS-1:0]   data_in,
    output logic                            result_valid,
    output logic [rbf_pkg::DATA_BITS-1:0]   data_out,
    output logic [1:0]                      status,
    output logic [rbf_pkg::CNT_W-1:0]       count_after,
    output logic                            is_empty,
    output logic                            is_full,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbf_pkg::SIZE_W-1:0]      cfg_data
);

    rbf_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Sequencer
    rbf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // Storage and pointers
    rbf_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .data_in     (data_in),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_out    (data_out),
        .status      (status),
        .count_after (count_after),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule

FILE: rtl/rbf_ctrl.sv
// Sequencing state machine for the ring buffer FIFO.
module rbf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             result_valid,
    output rbf_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_RESP);

endmodule

FILE: rtl/rbf_dpath.sv
// Storage, pointers, configuration registers and result registers of the FIFO.
module rbf_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rbf_pkg::dp_cmd_t                     cmd,
    input  logic [1:0]                           func,
    input  logic [rbf_pkg::DATA_BITS-1:0]        data_in,
    input  logic                                 cfg_we,
    input  logic [rbf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbf_pkg::SIZE_W-1:0]           cfg_data,
    output logic [rbf_pkg::DATA_BITS-1:0]        data_out,
    output logic [1:0]                           status,
    output logic [rbf_pkg::CNT_W-1:0]            count_after,
    output logic                                 is_empty,
    output logic                                 is_full
);

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_MARK = 2'd1,
        SEL_MEM  = 2'd2
    } dsel_t;

    // Advance an index by one, wrapping at the ring size
    function automatic logic [rbf_pkg::IDX_W-1:0] advance(
        input logic [rbf_pkg::IDX_W-1:0] idx,
        input logic [rbf_pkg::CNT_W-1:0] sz
    );
        logic [rbf_pkg::IDX_W:0] nxt;
        nxt = {1'b0, idx} + 1'b1;
        if (32'(nxt) >= 32'(sz))
        begin
            return '0;
        end
        return nxt[rbf_pkg::IDX_W-1:0];
    endfunction

    // Configuration registers
    logic [rbf_pkg::SIZE_W-1:0]    size_reg;
    logic                          ovw_reg;

    // Queue state
    logic [rbf_pkg::IDX_W-1:0]     head_reg, head_next;
    logic [rbf_pkg::IDX_W-1:0]     tail_reg, tail_next;
    logic [rbf_pkg::CNT_W-1:0]     count_reg, count_next;

    // Captured command
    rbf_pkg::func_t                op_reg;
    logic [rbf_pkg::DATA_BITS-1:0] opdata_reg;

    // Result registers
    dsel_t                         sel_reg, sel_next;
    rbf_pkg::status_t              stat_reg, stat_next;
    logic [rbf_pkg::CNT_W-1:0]     cnt_out_reg;
    logic                          empty_reg, full_reg;

    // Storage
    logic [rbf_pkg::DATA_BITS-1:0] mem [rbf_pkg::CAPACITY];
    logic [rbf_pkg::DATA_BITS-1:0] rd_data_reg;
    logic                          mem_we;
    logic [rbf_pkg::IDX_W-1:0]     rd_addr;

    logic [rbf_pkg::CNT_W-1:0]     sz;
    logic                          q_full, q_empty;
    logic [rbf_pkg::IDX_W-1:0]     tail_back;

    // Effective ring size: zero acts as one, oversize acts as capacity
    always_comb
    begin
        if (size_reg == '0)
        begin
            sz = rbf_pkg::CNT_W'(1);
        end
        else if (32'(size_reg) > 32'(rbf_pkg::CAPACITY))
        begin
            sz = rbf_pkg::CNT_W'(rbf_pkg::CAPACITY);
        end
        else
        begin
            sz = rbf_pkg::CNT_W'(size_reg);
        end
    end

    assign q_full    = (count_reg >= sz);
    assign q_empty   = (count_reg == '0);
    assign tail_back = (tail_reg == '0) ? rbf_pkg::IDX_W'(sz - 1'b1)
                                        : (tail_reg - 1'b1);

    // Operation decode: pointer, count and result updates
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        stat_next  = rbf_pkg::STAT_OK;
        sel_next   = SEL_ZERO;
        mem_we     = 1'b0;
        rd_addr    = head_reg;
        case (op_reg)
            rbf_pkg::FUNC_PUSH:
            begin
                if (q_full)
                begin
                    if (ovw_reg)
                    begin
                        mem_we    = cmd.exec;
                        tail_next = advance(tail_reg, sz);
                        head_next = advance(head_reg, sz);
                        stat_next = rbf_pkg::STAT_OVERWRITTEN;
                    end
                    else
                    begin
                        stat_next = rbf_pkg::STAT_REFUSED;
                    end
                end
                else
                begin
                    mem_we     = cmd.exec;
                    tail_next  = advance(tail_reg, sz);
                    count_next = count_reg + 1'b1;
                end
            end
            rbf_pkg::FUNC_POP:
            begin
                if (q_empty)
                begin
                    stat_next = rbf_pkg::STAT_EMPTY;
                    sel_next  = SEL_MARK;
                end
                else
                begin
                    sel_next   = SEL_MEM;
                    rd_addr    = head_reg;
                    head_next  = advance(head_reg, sz);
                    count_next = count_reg - 1'b1;
                end
            end
            rbf_pkg::FUNC_REMOVE:
            begin
                if (q_empty)
                begin
                    stat_next = rbf_pkg::STAT_EMPTY;
                    sel_next  = SEL_MARK;
                end
                else
                begin
                    sel_next   = SEL_MEM;
                    rd_addr    = tail_back;
                    tail_next  = tail_back;
                    count_next = count_reg - 1'b1;
                end
            end
            rbf_pkg::FUNC_FLUSH:
            begin
                head_next  = tail_reg;
                count_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= rbf_pkg::SIZE_W'(rbf_pkg::CAPACITY);
            ovw_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbf_pkg::CFG_SIZE_IN_USE: size_reg <= cfg_data;
                rbf_pkg::CFG_OVERWRITE:   ovw_reg  <= cfg_data[0];
                default:                  ovw_reg  <= ovw_reg;
            endcase
        end
    end

    // Queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Command capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= rbf_pkg::func_t'(func);
            opdata_reg <= data_in;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            sel_reg     <= sel_next;
            stat_reg    <= stat_next;
            cnt_out_reg <= count_next;
            empty_reg   <= (count_next == '0);
            full_reg    <= (count_next >= sz);
        end
    end

    // Storage array, one write or one registered read per operation
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= opdata_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result data select
    always_comb
    begin
        case (sel_reg)
            SEL_MARK: data_out = rbf_pkg::EMPTY_MARK;
            SEL_MEM:  data_out = rd_data_reg;
            default:  data_out = '0;
        endcase
    end

    assign status      = stat_reg;
    assign count_after = cnt_out_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the ring buffer FIFO with push, pop, remove-newest and flush.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rbf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 125;

    // Scoreboard: tracks the queue contents and checks every result in order
    class fifo_scoreboard;
        typedef struct {
            logic [DATA_BITS-1:0] data;
            status_t              status;
            logic [CNT_W-1:0]     count;
            logic                 empty;
            logic                 full;
        } reply_t;

        reply_t               pending_replies[$];
        logic [DATA_BITS-1:0] ring_data[CAPACITY];
        bit                   written[CAPACITY];
        int                   head;
        int                   tail;
        int                   count;
        int                   size_raw;
        bit                   overwrite;
        int                   mismatches;

        function new();
            head       = 0;
            tail       = 0;
            count      = 0;
            size_raw   = CAPACITY;
            overwrite  = 1'b0;
            mismatches = 0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                ring_data[i] = '0;
                written[i]   = 1'b0;
            end
        endfunction

        // Out-of-range sizes clamp to 1..CAPACITY
        function int ring_size();
            if (size_raw == 0)
                return 1;
            if (size_raw > CAPACITY)
                return CAPACITY;
            return size_raw;
        endfunction

        function int next_idx(int idx);
            return (idx + 1 >= ring_size()) ? 0 : idx + 1;
        endfunction

        function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
            if (idx == CFG_SIZE_IN_USE)
                size_raw = int'(val);
            else
                overwrite = val[0];
        endfunction

        // True when the operation would read a slot that never got data
        function bit reads_unwritten(func_t f);
            int t;
            if (count == 0)
                return 1'b0;
            if (f == FUNC_POP)
                return !written[head];
            if (f == FUNC_REMOVE)
            begin
                t = (tail == 0) ? ring_size() - 1 : tail - 1;
                return !written[t];
            end
            return 1'b0;
        endfunction

        // Apply one accepted operation and queue its result
        function void note_op(func_t f, logic [DATA_BITS-1:0] d);
            reply_t r;
            int     sz;
            sz     = ring_size();
            r.data   = '0;
            r.status = STAT_OK;
            case (f)
                FUNC_PUSH:
                begin
                    if (count >= sz)
                    begin
                        if (overwrite)
                        begin
                            ring_data[tail] = d;
                            written[tail]   = 1'b1;
                            tail            = next_idx(tail);
                            head            = next_idx(head);
                            r.status        = STAT_OVERWRITTEN;
                        end
                        else
                            r.status = STAT_REFUSED;
                    end
                    else
                    begin
                        ring_data[tail] = d;
                        written[tail]   = 1'b1;
                        tail            = next_idx(tail);
                        count++;
                    end
                end
                FUNC_POP:
                begin
                    if (count == 0)
                    begin
                        r.data   = EMPTY_MARK;
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        r.data = ring_data[head];
                        head   = next_idx(head);
                        count--;
                    end
                end
                FUNC_REMOVE:
                begin
                    if (count == 0)
                    begin
                        r.data   = EMPTY_MARK;
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        // tail steps back, wrapping from 0 to size-1
                        tail   = (tail == 0) ? sz - 1 : tail - 1;
                        r.data = ring_data[tail];
                        count--;
                    end
                end
                default:
                begin
                    head  = tail;
                    count = 0;
                end
            endcase
            r.count = CNT_W'(count);
            r.empty = (count == 0);
            r.full  = (count >= sz);
            pending_replies.push_back(r);
        endfunction

        function void check_result(logic [DATA_BITS-1:0] data, logic [1:0] status,
                                   logic [CNT_W-1:0] cnt, logic empty, logic full);
            reply_t r;
            if (pending_replies.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: data=%h status=%0d count=%0d",
                             data, status, cnt);
                mismatches++;
                return;
            end
            r = pending_replies.pop_front();
            if (data !== r.data || status !== r.status || cnt !== r.count ||
                empty !== r.empty || full !== r.full)
            begin
                if (mismatches < 10)
                    $display({"mismatch: exp data=%h st=%0d cnt=%0d e=%b f=%b",
                              " | got data=%h st=%0d cnt=%0d e=%b f=%b"},
                             r.data, r.status, r.count, r.empty, r.full,
                             data, status, cnt, empty, full);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic [1:0]           func      = '0;
    logic [DATA_BITS-1:0] data_in   = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data  = '0;
    logic                 busy;
    logic                 result_valid;
    logic [DATA_BITS-1:0] data_out;
    logic [1:0]           status;
    logic [CNT_W-1:0]     count_after;
    logic                 is_empty;
    logic                 is_full;
    logic                 cfg_ready;

    fifo_scoreboard sb = new();
    int             cycles = 0;

    ring_buffer_fifo_with_back_removal_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .data_in      (data_in),
        .result_valid (result_valid),
        .data_out     (data_out),
        .status       (status),
        .count_after  (count_after),
        .is_empty     (is_empty),
        .is_full      (is_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(data_out, status, count_after, is_empty, is_full);
    end

    // Issue one operation; start stays high so the caller may chain the next
    task automatic send_op(input func_t f, input logic [DATA_BITS-1:0] d);
        start   <= 1'b1;
        func    <= f;
        data_in <= d;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_op(f, d);
    endtask

    // Let every outstanding result arrive
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write both registers back to back, then drop valid
    task automatic write_cfg(input logic [SIZE_W-1:0] size, input logic ow);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SIZE_IN_USE;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_cfg(CFG_SIZE_IN_USE, size);
        // upper bits of the overwrite write are don't-care, so randomize them
        cfg_index <= CFG_OVERWRITE;
        cfg_data  <= {4'($urandom_range(0, 15)), ow};
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_cfg(CFG_OVERWRITE, {4'b0, ow});
        cfg_valid <= 1'b0;
    endtask

    // Random operation, steered away from reads of never-written slots
    task automatic pick_op(input int push_bias, output func_t f,
                           output logic [DATA_BITS-1:0] d);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_bias)
            f = FUNC_PUSH;
        else if (r < push_bias + (97 - push_bias) / 2)
            f = FUNC_POP;
        else if (r < 97)
            f = FUNC_REMOVE;
        else
            f = FUNC_FLUSH;
        if (sb.reads_unwritten(f))
            f = FUNC_PUSH;
        case ($urandom_range(0, 7))
            0:       d = '0;
            1:       d = '1;
            default: d = DATA_BITS'($urandom_range(0, 255));
        endcase
    endtask

    function automatic int gap_len(bit idle_on);
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        func_t                f;
        logic [DATA_BITS-1:0] d;
        logic [SIZE_W-1:0]    size_sel;
        int                   bias;
        int                   g;
        bit                   idle_on;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, data extremes, both ends
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_REMOVE, 8'h00);
        send_op(FUNC_FLUSH, 8'h00);
        send_op(FUNC_PUSH, 8'h00);
        send_op(FUNC_PUSH, 8'hFF);
        send_op(FUNC_REMOVE, 8'h00);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_POP, 8'h00);
        drain();

        // Size zero acts as one: refused push, remove wrapping at zero
        write_cfg(5'd0, 1'b0);
        send_op(FUNC_PUSH, 8'hA5);
        send_op(FUNC_PUSH, 8'h5A);
        send_op(FUNC_REMOVE, 8'h00);
        send_op(FUNC_PUSH, 8'h3C);
        send_op(FUNC_FLUSH, 8'h00);
        drain();

        // Overwrite on full, then remove across the wrap
        write_cfg(5'd3, 1'b1);
        send_op(FUNC_PUSH, 8'h11);
        send_op(FUNC_PUSH, 8'h22);
        send_op(FUNC_PUSH, 8'h33);
        send_op(FUNC_PUSH, 8'h44);
        send_op(FUNC_PUSH, 8'h55);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_REMOVE, 8'h00);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_POP, 8'h00);
        drain();

        // Random phases, each with its own ring size and overwrite mode
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       size_sel = 5'd1;
                1:       size_sel = 5'd16;
                2:       size_sel = 5'd0;
                3:       size_sel = 5'd31;
                4:       size_sel = 5'd2;
                5:       size_sel = SIZE_W'($urandom_range(1, 16));
                6:       size_sel = 5'd5;
                default: size_sel = SIZE_W'($urandom_range(0, 31));
            endcase
            // sometimes empty the queue first, sometimes resize with entries held
            if ($urandom_range(0, 1))
            begin
                send_op(FUNC_FLUSH, DATA_BITS'($urandom_range(0, 255)));
                drain();
            end
            write_cfg(size_sel, p[0] ^ 1'($urandom_range(0, 1)));
            case ($urandom_range(0, 2))
                0:       bias = 30;
                1:       bias = 48;
                default: bias = 70;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick_op(bias, f, d);
                send_op(f, d);
                if ($urandom_range(0, 99) == 0)
                    drain();
                else
                begin
                    g = gap_len(idle_on);
                    if (g > 0)
                    begin
                        start <= 1'b0;
                        repeat (g) @(posedge clk);
                    end
                end
            end
            drain();
        end

        // Wind down and report
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
